// ----- hdl/fru_multirecord_stream_parser_top_macros.svh -----
// assertion macros used by the multirecord parser core
`ifndef FRU_MULTIRECORD_STREAM_PARSER_TOP_MACROS_SVH
`define FRU_MULTIRECORD_STREAM_PARSER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// expression holds at every clock edge outside reset
`define FRU_ASSERT_ALWAYS(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");
// consequent holds in the same cycle as the antecedent
`define FRU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
// consequent holds in the cycle after the antecedent
`define FRU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next cycle");
`else
`define FRU_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define FRU_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define FRU_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// ----- hdl/fru_mr_pkg.sv -----
// types and constants of the multirecord parser
package fru_mr_pkg;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 11;
  localparam int LIMIT_W    = 13;
  localparam int LIMIT_MAX  = 8191;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [LIMIT_W-1:0] AREA_LIMIT_RESET = 13'd4096;
  localparam logic [0:0]         REG_AREA_LIMIT   = 1'b0;

  localparam logic [2:0] HDR_LAST_POS = 3'd4;
  localparam logic [2:0] FMT_IPMI     = 3'h2;
  localparam int         ROOM_HEADER  = 5;
  localparam logic [7:0] COUNT_MAX    = 8'hFF;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DATA   = 3'b010,
    PH_STOP   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HDR_SUM     = 3'd1,
    ST_FORMAT      = 3'd2,
    ST_DATA_SUM    = 3'd3,
    ST_ROOM_HEADER = 3'd4,
    ST_ROOM_DATA   = 3'd5
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] in_byte;
    logic              area_start;
  } item_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  data_index;
    logic [BYTE_W-1:0] record_type;
    logic [LEN_W-1:0]  record_length;
    logic [BYTE_W-1:0] record_index;
    status_t           status;
    logic              last_record;
  } result_t;

endpackage

// ----- hdl/fru_mr_if.sv -----
// stream channel interfaces of the multirecord parser
interface fru_mr_in_if;
  import fru_mr_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              area_start;
  modport source(output valid, output in_byte, output area_start, input ready);
  modport sink(input valid, input in_byte, input area_start, output ready);
endinterface

interface fru_mr_out_if;
  import fru_mr_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [BYTE_W-1:0] data_byte;
  logic [LEN_W-1:0]  data_index;
  logic [BYTE_W-1:0] record_type;
  logic [LEN_W-1:0]  record_length;
  logic [BYTE_W-1:0] record_index;
  logic [2:0]        status;
  logic              last_record;
  modport source(output valid, output kind, output data_byte, output data_index,
                 output record_type, output record_length, output record_index,
                 output status, output last_record, input ready);
  modport sink(input valid, input kind, input data_byte, input data_index,
               input record_type, input record_length, input record_index,
               input status, input last_record, output ready);
endinterface

// ----- hdl/fru_multirecord_stream_parser_top.sv -----
// top level of the ipmi fru multirecord stream parser
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    in_byte, area_start
//  out_ch    out  valid / ready    kind, data_byte, data_index, record_type,
//                                  record_length, record_index, status, last_record
//  apb       in   psel / penable   area_limit at byte address 0
//
// one byte per cycle sustained while out_ch stays ready; a byte is held in the input
// register while the parser pass runs, and the result register loads when the parser
// steps, so a result shows once it has passed the input and result registers.
// rst is synchronous: area_limit returns to 4096 and the parser to area start
// a result held by out_ch stalls the parser; the input register still takes
// one more request if it is empty, after that in_ch.ready drops
module fru_multirecord_stream_parser_top #(
  parameter int AREA_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  fru_mr_in_if.sink                     in_ch,
  fru_mr_out_if.source                  out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fru_mr_pkg::ADDR_W-1:0] paddr,
  input  logic [fru_mr_pkg::DATA_W-1:0] pwdata,
  output logic [fru_mr_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);
  import fru_mr_pkg::*;

  logic               item_valid;
  item_t              item;
  logic               out_free;
  logic               step;
  logic               res_valid;
  result_t            res;
  logic [LIMIT_W-1:0] area_limit;

  // the parser advances whenever a byte is waiting and the result slot is free
  assign step = item_valid && out_free;

  fru_mr_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .area_limit (area_limit)
  );

  // byte staging ahead of the parser
  fru_mr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .take       (step),
    .item_valid (item_valid),
    .item       (item),
    .in_ch      (in_ch)
  );

  // header, data and room checks, one byte per pass
  fru_mr_core #(
    .AREA_BYTES (AREA_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (item),
    .area_limit (area_limit),
    .res_valid  (res_valid),
    .res        (res)
  );

  // results only load on a step that produced one
  fru_mr_out_reg u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (step && res_valid),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule

// ----- hdl/fru_mr_cfg.sv -----
// apb register block holding the area limit
module fru_mr_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fru_mr_pkg::ADDR_W-1:0] paddr,
  input  logic [fru_mr_pkg::DATA_W-1:0] pwdata,
  output logic [fru_mr_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output logic [fru_mr_pkg::LIMIT_W-1:0] area_limit
);
  import fru_mr_pkg::*;

  logic       hit;
  logic       wr;

  assign hit    = (paddr[ADDR_W-1:2] == REG_AREA_LIMIT);
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = hit ? DATA_W'(area_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      area_limit <= AREA_LIMIT_RESET;
    end else if (wr && hit) begin
      area_limit <= pwdata[LIMIT_W-1:0];
    end
  end

endmodule

// ----- hdl/fru_mr_in_reg.sv -----
// input register in front of the parser
module fru_mr_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  output logic              item_valid,
  output fru_mr_pkg::item_t item,
  fru_mr_in_if.sink         in_ch
);
  import fru_mr_pkg::*;

  logic accept;

  assign in_ch.ready = !item_valid || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.in_byte    <= in_ch.in_byte;
      item.area_start <= in_ch.area_start;
    end
  end

endmodule

// ----- hdl/fru_mr_core.sv -----
// parser state and per-byte header, data and room checks
`include "fru_multirecord_stream_parser_top_macros.svh"

module fru_mr_core #(
  parameter int AREA_BYTES = 4096
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  fru_mr_pkg::item_t              item,
  input  logic [fru_mr_pkg::LIMIT_W-1:0] area_limit,
  output logic                           res_valid,
  output fru_mr_pkg::result_t            res
);
  import fru_mr_pkg::*;

  localparam int LIM_MAX = (AREA_BYTES < LIMIT_MAX) ? AREA_BYTES : LIMIT_MAX;
  localparam int UW      = $clog2(LIM_MAX + 1);
  localparam int CW      = LIMIT_W + 1;

  phase_t            phase, phase_next;
  logic [2:0]        header_pos, header_pos_next;
  logic [7:0]        header_sum, header_sum_next;
  logic [7:0]        type_reg, type_reg_next;
  logic              end_flag, end_flag_next;
  logic [2:0]        fmt_reg, fmt_reg_next;
  logic [LEN_W-1:0]  length_reg, length_reg_next;
  logic [7:0]        data_check, data_check_next;
  logic [7:0]        data_sum, data_sum_next;
  logic [LEN_W-1:0]  data_pos, data_pos_next;
  logic [UW-1:0]     area_used, area_used_next;
  logic [7:0]        record_count, record_count_next;

  // state as seen after an optional restart
  phase_t            c_phase;
  logic [2:0]        c_hpos;
  logic [7:0]        c_hsum, c_type, c_dcheck, c_dsum, c_count;
  logic              c_end;
  logic [2:0]        c_fmt;
  logic [LEN_W-1:0]  c_len, c_dpos;
  logic [UW-1:0]     c_used;

  logic [7:0]        b;
  logic [CW-1:0]     lim, used_c, used_i, room0, room1;
  logic [7:0]        hsum_i, dsum_i, count_inc;
  logic [LEN_W:0]    dpos_inc;

  assign b = item.in_byte;

  always_comb begin
    if (item.area_start) begin
      c_phase  = PH_HEADER;
      c_hpos   = '0;
      c_hsum   = '0;
      c_type   = '0;
      c_end    = 1'b0;
      c_fmt    = '0;
      c_len    = '0;
      c_dcheck = '0;
      c_dsum   = '0;
      c_dpos   = '0;
      c_used   = '0;
      c_count  = '0;
    end else begin
      c_phase  = phase;
      c_hpos   = header_pos;
      c_hsum   = header_sum;
      c_type   = type_reg;
      c_end    = end_flag;
      c_fmt    = fmt_reg;
      c_len    = length_reg;
      c_dcheck = data_check;
      c_dsum   = data_sum;
      c_dpos   = data_pos;
      c_used   = area_used;
      c_count  = record_count;
    end
  end

  // room left before and after this byte is counted
  assign lim       = (CW'(area_limit) > CW'(LIM_MAX)) ? CW'(LIM_MAX) : CW'(area_limit);
  assign used_c    = CW'(c_used);
  assign used_i    = CW'(c_used) + CW'(1);
  assign room0     = (lim > used_c) ? (lim - used_c) : '0;
  assign room1     = (lim > used_i) ? (lim - used_i) : '0;
  assign hsum_i    = c_hsum + b;
  assign dsum_i    = c_dsum + b;
  assign count_inc = (c_count == COUNT_MAX) ? c_count : c_count + 8'd1;
  assign dpos_inc  = {1'b0, c_dpos} + {{LEN_W{1'b0}}, 1'b1};

  always_comb begin
    phase_next        = c_phase;
    header_pos_next   = c_hpos;
    header_sum_next   = c_hsum;
    type_reg_next     = c_type;
    end_flag_next     = c_end;
    fmt_reg_next      = c_fmt;
    length_reg_next   = c_len;
    data_check_next   = c_dcheck;
    data_sum_next     = c_dsum;
    data_pos_next     = c_dpos;
    area_used_next    = c_used;
    record_count_next = c_count;

    res_valid         = 1'b0;
    res.kind          = 1'b1;
    res.data_byte     = '0;
    res.data_index    = '0;
    res.record_type   = c_type;
    res.record_length = c_len;
    res.record_index  = c_count;
    res.status        = ST_OK;
    res.last_record   = 1'b1;

    unique case (c_phase)
      PH_HEADER: begin
        if (c_hpos == 3'd0 && room0 < CW'(ROOM_HEADER)) begin
          // not even room for a header: byte is not counted against the area
          type_reg_next     = '0;
          length_reg_next   = '0;
          res_valid         = 1'b1;
          res.record_type   = '0;
          res.record_length = '0;
          res.status        = ST_ROOM_HEADER;
          phase_next        = PH_STOP;
        end else begin
          header_sum_next = hsum_i;
          area_used_next  = c_used + UW'(1);
          unique case (c_hpos)
            3'd0: type_reg_next = b;
            3'd1: begin
              fmt_reg_next  = b[2:0];
              end_flag_next = b[3];
            end
            3'd2: length_reg_next = {b, 3'b000};
            3'd3: data_check_next = b;
            default: ;
          endcase
          if (c_hpos < HDR_LAST_POS) begin
            header_pos_next = c_hpos + 3'd1;
          end else begin
            header_pos_next = '0;
            priority if (hsum_i != 8'd0) begin
              res_valid  = 1'b1;
              res.status = ST_HDR_SUM;
              phase_next = PH_STOP;
            end else if (c_fmt != FMT_IPMI) begin
              res_valid  = 1'b1;
              res.status = ST_FORMAT;
              phase_next = PH_STOP;
            end else if (room1 < CW'(c_len)) begin
              res_valid  = 1'b1;
              res.status = ST_ROOM_DATA;
              phase_next = PH_STOP;
            end else begin
              data_sum_next = '0;
              data_pos_next = '0;
              if (c_len == '0) begin
                // empty record closes at once, data sum is only the check byte
                res_valid = 1'b1;
                if (c_dcheck != 8'd0) begin
                  res.status = ST_DATA_SUM;
                  phase_next = PH_STOP;
                end else begin
                  res.last_record   = c_end;
                  record_count_next = count_inc;
                  header_sum_next   = '0;
                  phase_next        = c_end ? PH_STOP : PH_HEADER;
                end
              end else begin
                phase_next = PH_DATA;
              end
            end
          end
        end
      end
      PH_DATA: begin
        area_used_next = c_used + UW'(1);
        data_sum_next  = dsum_i;
        res_valid      = 1'b1;
        res.data_byte  = b;
        res.data_index = c_dpos;
        if (dpos_inc < {1'b0, c_len}) begin
          res.kind        = 1'b0;
          res.last_record = 1'b0;
          data_pos_next   = dpos_inc[LEN_W-1:0];
        end else if (dsum_i + c_dcheck != 8'd0) begin
          res.status = ST_DATA_SUM;
          phase_next = PH_STOP;
        end else begin
          // last data byte rides in the record summary
          res.last_record   = c_end;
          record_count_next = count_inc;
          header_pos_next   = '0;
          header_sum_next   = '0;
          phase_next        = c_end ? PH_STOP : PH_HEADER;
        end
      end
      default: begin
        // stopped: bytes are dropped until the next area start
        phase_next = PH_STOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      header_pos   <= '0;
      header_sum   <= '0;
      type_reg     <= '0;
      end_flag     <= 1'b0;
      fmt_reg      <= '0;
      length_reg   <= '0;
      data_check   <= '0;
      data_sum     <= '0;
      data_pos     <= '0;
      area_used    <= '0;
      record_count <= '0;
    end else if (step) begin
      phase        <= phase_next;
      header_pos   <= header_pos_next;
      header_sum   <= header_sum_next;
      type_reg     <= type_reg_next;
      end_flag     <= end_flag_next;
      fmt_reg      <= fmt_reg_next;
      length_reg   <= length_reg_next;
      data_check   <= data_check_next;
      data_sum     <= data_sum_next;
      data_pos     <= data_pos_next;
      area_used    <= area_used_next;
      record_count <= record_count_next;
    end
  end

  `FRU_ASSERT_IMP(a_stop_silent, clk, rst, phase == PH_STOP && !item.area_start, !res_valid)
  `FRU_ASSERT_IMP(a_data_pos, clk, rst, phase == PH_DATA, data_pos < length_reg)
  `FRU_ASSERT_ALWAYS(a_used_bound, clk, rst, CW'(area_used) <= CW'(LIM_MAX))
  `FRU_ASSERT_IMP(a_data_ok, clk, rst, res_valid && !res.kind, res.status == ST_OK && !res.last_record)
  `FRU_ASSERT_NEXT(a_last_stops, clk, rst, step && res_valid && res.last_record, phase == PH_STOP)

endmodule

// ----- hdl/fru_mr_out_reg.sv -----
// result register driving the output channel
module fru_mr_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  fru_mr_pkg::result_t res,
  output logic                free,
  fru_mr_out_if.source        out_ch
);
  import fru_mr_pkg::*;

  logic    out_valid;
  result_t hold;

  assign free = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.kind          = hold.kind;
  assign out_ch.data_byte     = hold.data_byte;
  assign out_ch.data_index    = hold.data_index;
  assign out_ch.record_type   = hold.record_type;
  assign out_ch.record_length = hold.record_length;
  assign out_ch.record_index  = hold.record_index;
  assign out_ch.status        = hold.status;
  assign out_ch.last_record   = hold.last_record;

endmodule

// ----- dv/tb.sv -----
// self-checking testbench of the fru multirecord stream parser
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fru_mr_pkg::*;

  localparam int AREA_BYTES    = 4096;
  localparam int RST_CYCLES    = 8;
  // a result passes the input and result registers after its request; a request with no result
  // may still sit in the pipe when the last awaited result has arrived
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 300;
  localparam int PRINT_CAP     = 40;
  localparam int CYCLE_LIMIT   = 200000;

  // what one row of the directed table does
  typedef enum logic {
    ROW_BYTE  = 1'b0,
    ROW_LIMIT = 1'b1
  } row_op_e;

  // ways the record generator can spoil a record
  typedef enum int {
    FLAW_HDR_SUM  = 0,
    FLAW_FORMAT   = 1,
    FLAW_DATA_SUM = 2,
    FLAW_NONE     = 3
  } flaw_e;

  typedef struct packed {
    row_op_e            op;
    logic [LIMIT_W-1:0] limit;
    logic [7:0]         b;
    logic               start;
    logic               typed;
    result_t            res;
  } stim_row_t;

  localparam result_t NO_RES = '0;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  fru_mr_in_if  in_ch ();
  fru_mr_out_if out_ch ();

  fru_multirecord_stream_parser_top #(
    .AREA_BYTES(AREA_BYTES)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle rates in percent, changed between phases
  int send_gap_pct;
  int ready_gap_pct;
  bit hold_req;
  int mismatch_count;
  int cycle_count;

  // results the parser still owes, oldest first
  result_t awaited[$];

  // ---------------------------------------------------------------------
  // parser state as the predictor sees it
  // ---------------------------------------------------------------------
  logic [LIMIT_W-1:0] area_limit_m;
  phase_t             ph;
  logic [2:0]         hdr_pos;
  logic [2:0]         fmt_m;
  logic [7:0]         hdr_sum;
  logic [7:0]         rec_type;
  logic [7:0]         dcheck;
  logic [7:0]         dsum;
  logic [7:0]         rec_count;
  logic               end_m;
  logic [LEN_W-1:0]   rec_len;
  logic [LEN_W-1:0]   dpos;
  logic [LIMIT_W-1:0] used;

  // restart at the first byte of an area
  function automatic void clear_area();
    ph        = PH_HEADER;
    hdr_pos   = '0;
    hdr_sum   = '0;
    rec_type  = '0;
    end_m     = 1'b0;
    fmt_m     = '0;
    rec_len   = '0;
    dcheck    = '0;
    dsum      = '0;
    dpos      = '0;
    used      = '0;
    rec_count = '0;
  endfunction

  // a limit above the area size acts as the area size
  function automatic int unsigned room_left();
    int unsigned lim;
    lim = (area_limit_m > AREA_BYTES) ? AREA_BYTES : area_limit_m;
    return (lim > used) ? lim - used : 0;
  endfunction

  function automatic result_t make_result(input logic k, input logic [7:0] db,
                                          input logic [LEN_W-1:0] di,
                                          input status_t st, input logic fin);
    result_t r;
    r.kind          = k;
    r.data_byte     = db;
    r.data_index    = di;
    r.record_type   = rec_type;
    r.record_length = rec_len;
    r.record_index  = rec_count;
    r.status        = st;
    r.last_record   = fin;
    return r;
  endfunction

  // any error ends parsing until the next area start
  function automatic result_t stop_with(input status_t st, input logic [7:0] db,
                                        input logic [LEN_W-1:0] di);
    ph = PH_STOP;
    return make_result(1'b1, db, di, st, 1'b1);
  endfunction

  // record summary once its data is complete
  function automatic result_t close_record(input logic [7:0] db,
                                           input logic [LEN_W-1:0] di);
    result_t r;
    if (8'(dsum + dcheck) != 8'd0) return stop_with(ST_DATA_SUM, db, di);
    r = make_result(1'b1, db, di, ST_OK, end_m);
    if (rec_count != COUNT_MAX) rec_count++;
    hdr_pos = '0;
    hdr_sum = '0;
    ph = end_m ? PH_STOP : PH_HEADER;
    return r;
  endfunction

  // one accepted request through the parser; 1 when it gives a result
  function automatic bit parse_byte(input logic [7:0] b, input logic start,
                                    output result_t r);
    r = '0;
    if (start) clear_area();
    if (ph == PH_STOP) return 1'b0;

    if (ph == PH_HEADER) begin
      // room check on the first header byte, which is then not counted as used
      if (hdr_pos == 3'd0 && room_left() < ROOM_HEADER) begin
        rec_type = '0;
        rec_len  = '0;
        r = stop_with(ST_ROOM_HEADER, 8'd0, '0);
        return 1'b1;
      end
      hdr_sum += b;
      used++;
      case (hdr_pos)
        3'd0: rec_type = b;
        3'd1: begin
          fmt_m = b[2:0];
          end_m = b[3];
        end
        3'd2: rec_len = {b, 3'b000};
        3'd3: dcheck = b;
        default: ;
      endcase
      if (hdr_pos != HDR_LAST_POS) begin
        hdr_pos++;
        return 1'b0;
      end
      hdr_pos = '0;
      if (hdr_sum != 8'd0) begin
        r = stop_with(ST_HDR_SUM, 8'd0, '0);
        return 1'b1;
      end
      if (fmt_m != FMT_IPMI) begin
        r = stop_with(ST_FORMAT, 8'd0, '0);
        return 1'b1;
      end
      if (room_left() < rec_len) begin
        r = stop_with(ST_ROOM_DATA, 8'd0, '0);
        return 1'b1;
      end
      dsum = '0;
      dpos = '0;
      if (rec_len == '0) begin
        r = close_record(8'd0, '0);
        return 1'b1;
      end
      ph = PH_DATA;
      return 1'b0;
    end

    // data phase: the last data byte turns into the summary
    used++;
    dsum += b;
    if (int'(dpos) + 1 < int'(rec_len)) begin
      r = make_result(1'b0, b, dpos, ST_OK, 1'b0);
      dpos++;
      return 1'b1;
    end
    r = close_record(b, dpos);
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t ns: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_record(input result_t got);
    result_t want;
    if (awaited.size() == 0) begin
      report_mismatch("result with nothing awaited, kind", got.kind, -1);
      return;
    end
    want = awaited.pop_front();
    if (got.kind != want.kind)
      report_mismatch("kind", got.kind, want.kind);
    if (got.data_byte != want.data_byte)
      report_mismatch("data_byte", got.data_byte, want.data_byte);
    if (got.data_index != want.data_index)
      report_mismatch("data_index", got.data_index, want.data_index);
    if (got.record_type != want.record_type)
      report_mismatch("record_type", got.record_type, want.record_type);
    if (got.record_length != want.record_length)
      report_mismatch("record_length", got.record_length, want.record_length);
    if (got.record_index != want.record_index)
      report_mismatch("record_index", got.record_index, want.record_index);
    if (got.status != want.status)
      report_mismatch("status", int'(got.status), int'(want.status));
    if (got.last_record != want.last_record)
      report_mismatch("last_record", got.last_record, want.last_record);
  endtask

  // result side: sample at the edge, then pick ready for the next cycle;
  // a hold request parks ready low for a long stretch so that the parser
  // backs up and drops in_ch.ready
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready)
        check_record('{out_ch.kind, out_ch.data_byte, out_ch.data_index,
                       out_ch.record_type, out_ch.record_length,
                       out_ch.record_index, status_t'(out_ch.status),
                       out_ch.last_record});
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= ready_gap_pct);
      end
    end
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------

  // offer one request, maybe after a gap; valid stays up between
  // back-to-back requests so it never gets two updates in one step
  task automatic send_byte(input logic [7:0] b, input logic start,
                           input bit typed = 1'b0, input result_t typed_res = '0);
    result_t r;
    if ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.area_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    // table rows with a typed result override the predictor's
    if (parse_byte(b, start, r)) awaited.push_back(typed ? typed_res : r);
  endtask

  // drain the parser before touching the register
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_area_limit(input logic [LIMIT_W-1:0] v);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(4 * int'(REG_AREA_LIMIT));
    pwdata  <= DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    area_limit_m = v;
  endtask

  // one area of well-formed records with random content; with flaws on,
  // some records get a bad header sum, an unknown format or a bad data
  // sum, and the area is cut short after the spoiled record
  task automatic send_area(input int n_rec, input int min_units, input int max_units,
                           input bit flaws);
    logic [7:0] rec_hdr [5];
    logic [7:0] body [$];
    logic [7:0] sum;
    int         units;
    flaw_e      flaw;
    bit         end_rec;
    bit         first;
    first = 1'b1;
    for (int n = 0; n < n_rec; n++) begin
      flaw    = flaws ? flaw_e'($urandom_range(11)) : FLAW_NONE;
      if (flaw > FLAW_NONE) flaw = FLAW_NONE;
      end_rec = (n == n_rec - 1) ? ($urandom_range(3) != 0)
                                 : (flaws && $urandom_range(24) == 0);
      units   = $urandom_range(max_units, min_units);
      body.delete();
      sum = '0;
      repeat (units * 8) begin
        body.push_back(8'($urandom_range(255)));
        sum += body[$];
      end
      rec_hdr[0] = 8'($urandom_range(255));
      rec_hdr[1] = {4'($urandom_range(15)), end_rec, FMT_IPMI};
      if (flaw == FLAW_FORMAT) rec_hdr[1][2:0] = FMT_IPMI ^ 3'($urandom_range(7, 1));
      rec_hdr[2] = 8'(units);
      rec_hdr[3] = -sum;
      // also spoils zero-length records, whose empty data still gets summed
      if (flaw == FLAW_DATA_SUM) rec_hdr[3] += 8'($urandom_range(255, 1));
      rec_hdr[4] = -(rec_hdr[0] + rec_hdr[1] + rec_hdr[2] + rec_hdr[3]);
      if (flaw == FLAW_HDR_SUM) rec_hdr[4] += 8'($urandom_range(255, 1));
      for (int i = 0; i < 5; i++) begin
        send_byte(rec_hdr[i], first);
        first = 1'b0;
      end
      foreach (body[i]) send_byte(body[i], 1'b0);
      if (flaw != FLAW_NONE || end_rec) break;
    end
  endtask

  // loose bytes, now and then with a stray area start
  task automatic send_noise(input int count);
    repeat (count) send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
  endtask

  // mostly short areas, with noise in between
  task automatic run_areas(input int n_areas, input int max_units);
    repeat (n_areas) begin
      send_area($urandom_range(6, 1), 0, max_units, 1'b1);
      if ($urandom_range(3) == 0) send_noise($urandom_range(8, 1));
    end
  endtask

  // directed part: record without data before any area start, an end
  // record with extreme data bytes, a stray byte after the stop, no room
  // for a header, and a bad header sum under an oversized limit
  stim_row_t stim_table [27] = '{
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h02, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hFE, 1'b0, 1'b1,
      '{1'b1, 8'h00, 11'd0, 8'h00, 11'd0, 8'd0, ST_OK, 1'b0}},
    '{ROW_BYTE,  13'd0,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h0A, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h01, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h04, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hF2, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b1,
      '{1'b1, 8'h00, 11'd7, 8'hFF, 11'd8, 8'd1, ST_OK, 1'b1}},
    '{ROW_BYTE,  13'd0,    8'h5A, 1'b0, 1'b0, NO_RES},
    '{ROW_LIMIT, 13'd4,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h33, 1'b1, 1'b1,
      '{1'b1, 8'h00, 11'd0, 8'h00, 11'd0, 8'd0, ST_ROOM_HEADER, 1'b1}},
    '{ROW_LIMIT, 13'd8191, 8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h80, 1'b1, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h07, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'hFF, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b0, NO_RES},
    '{ROW_BYTE,  13'd0,    8'h00, 1'b0, 1'b1,
      '{1'b1, 8'h00, 11'd0, 8'h80, 11'd2040, 8'd0, ST_HDR_SUM, 1'b1}}
  };

  initial begin
    // every input known from time zero
    rst              <= 1'b1;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= '0;
    in_ch.area_start <= 1'b0;
    out_ch.ready     <= 1'b0;
    hold_req       = 1'b0;
    mismatch_count = 0;
    area_limit_m   = AREA_LIMIT_RESET;
    clear_area();

    // sender idles a third of the time, receiver two thirds
    send_gap_pct  = 34;
    ready_gap_pct = 69;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (stim_table[i]) begin
      if (stim_table[i].op == ROW_LIMIT)
        write_area_limit(stim_table[i].limit);
      else
        send_byte(stim_table[i].b, stim_table[i].start, stim_table[i].typed,
                  stim_table[i].res);
    end

    // mid-size limit, mixed records
    write_area_limit(13'($urandom_range(1000, 300)));
    run_areas(4, 3);

    // idling swapped: tight limits bring both room errors
    send_gap_pct  = 69;
    ready_gap_pct = 34;
    write_area_limit('0);
    run_areas(2, 2);
    write_area_limit(13'($urandom_range(90, 20)));
    // long receiver stall while requests keep coming
    hold_req = 1'b1;
    run_areas(4, 4);
    write_area_limit(13'(ROOM_HEADER));
    run_areas(2, 1);

    // no idling: a clean area of short records, then a random limit
    // that may exceed the area size
    send_gap_pct  = 0;
    ready_gap_pct = 0;
    write_area_limit(AREA_LIMIT_RESET);
    send_area(4, 0, 2, 1'b0);
    write_area_limit(13'($urandom_range(LIMIT_MAX, 100)));
    run_areas(3, 3);

    settle();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
